/* rtl/smt_pkg.sv */
`timescale 1ns / 1ps
package smt_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int DATA_W   = 32;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_UPDATE = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_INDEX    = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] key_value;
        logic signed [31:0] replacement;
        logic               all_matches;
        logic [5:0]         match_limit;
        logic [4:0]         read_index;
    } item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [5:0]         entry_count;
        logic signed [31:0] read_value;
    } result_t;

    typedef struct packed {
        logic                     rd_en;
        logic [IDX_W-1:0]         rd_addr;
        logic                     wr_en;
        logic [IDX_W-1:0]         wr_addr;
        logic signed [DATA_W-1:0] wr_data;
    } mem_req_t;

endpackage

/* rtl/smt_ram.sv */
`timescale 1ns / 1ps
module smt_ram (
    input  logic                             aclk,
    input  smt_pkg::mem_req_t                req,
    output logic signed [smt_pkg::DATA_W-1:0] rd_data
);
    import smt_pkg::*;

    logic signed [DATA_W-1:0] mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

/* rtl/smt_ctrl.sv */
`timescale 1ns / 1ps
module smt_ctrl (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  smt_pkg::item_t                    item,
    output logic                              idle,
    input  logic                              out_free,
    output logic                              done,
    output smt_pkg::result_t                  res,
    output smt_pkg::mem_req_t                 mem_req,
    input  logic signed [smt_pkg::DATA_W-1:0] rd_data
);
    import smt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_FILL = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     pend_reg, pend_next;
    logic [1:0]               op_reg, op_next;
    logic signed [DATA_W-1:0] key_reg, key_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]         limit_reg, limit_next;
    logic [CNT_W-1:0]         r_reg, r_next;
    logic [CNT_W-1:0]         w_reg, w_next;
    logic [CNT_W-1:0]         a_reg, a_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [2:0]               status_reg, status_next;
    logic signed [DATA_W-1:0] rv_reg, rv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        limit_reg  <= limit_next;
        r_reg      <= r_next;
        w_reg      <= w_next;
        a_reg      <= a_next;
        n_reg      <= n_next;
        status_reg <= status_next;
        rv_reg     <= rv_next;
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        pend_next   = pend_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        limit_next  = limit_reg;
        r_next      = r_reg;
        w_next      = w_reg;
        a_next      = a_reg;
        n_next      = n_reg;
        status_next = status_reg;
        rv_next     = rv_reg;
        mem_req     = '0;
        done        = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (start) begin
                    op_next     = item.operation;
                    key_next    = item.key_value;
                    val_next    = item.key_value;
                    rv_next     = '0;
                    status_next = ST_OK;
                    pend_next   = 1'b0;
                    n_next      = '0;
                    r_next      = '0;
                    w_next      = '0;
                    if (item.all_matches || (32'(item.match_limit) >= CAPACITY)) begin
                        limit_next = CNT_W'(CAPACITY);
                    end else begin
                        limit_next = CNT_W'(item.match_limit);
                    end
                    unique case (item.operation)
                        OP_INSERT: begin
                            if (32'(count_reg) == CAPACITY) begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                n_next     = CNT_W'(1);
                                r_next     = count_reg;
                                state_next = S_INS;
                            end
                        end
                        OP_DELETE: begin
                            if (count_reg == '0) begin
                                status_next = ST_EMPTY;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_CMP;
                            end
                        end
                        OP_UPDATE: begin
                            val_next   = item.replacement;
                            state_next = S_CMP;
                        end
                        OP_READ: begin
                            if (32'(item.read_index) < 32'(count_reg)) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = IDX_W'(item.read_index);
                                state_next      = S_RD;
                            end else begin
                                status_next = ST_INDEX;
                                state_next  = S_DONE;
                            end
                        end
                    endcase
                end
            end

            // walk down from the top, moving larger entries up by n_reg places
            S_INS: begin
                if (pend_reg && !(rd_data > val_reg)) begin
                    w_next     = a_reg + CNT_W'(1);
                    pend_next  = 1'b0;
                    state_next = S_FILL;
                end else begin
                    if (pend_reg) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = IDX_W'(a_reg + n_reg);
                        mem_req.wr_data = rd_data;
                    end
                    if (r_reg != '0) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = IDX_W'(r_reg - CNT_W'(1));
                        a_next          = r_reg - CNT_W'(1);
                        r_next          = r_reg - CNT_W'(1);
                        pend_next       = 1'b1;
                    end else if (pend_reg) begin
                        pend_next = 1'b0;
                    end else begin
                        w_next     = '0;
                        state_next = S_FILL;
                    end
                end
            end

            // compact the table, dropping up to limit_reg entries equal to the key
            S_CMP: begin
                if (pend_reg) begin
                    if ((rd_data == key_reg) && (n_reg < limit_reg)) begin
                        n_next = n_reg + CNT_W'(1);
                    end else begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = IDX_W'(w_reg);
                        mem_req.wr_data = rd_data;
                        w_next          = w_reg + CNT_W'(1);
                    end
                end
                if (r_reg < count_reg) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(r_reg);
                    r_next          = r_reg + CNT_W'(1);
                    pend_next       = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (n_reg == '0) begin
                            status_next = ST_NOTFOUND;
                            state_next  = S_DONE;
                        end else if (op_reg == OP_DELETE) begin
                            count_next = count_reg - n_reg;
                            state_next = S_DONE;
                        end else begin
                            // reinsert n_reg copies of the replacement
                            count_next = count_reg - n_reg;
                            r_next     = count_reg - n_reg;
                            state_next = S_INS;
                        end
                    end
                end
            end

            S_FILL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = IDX_W'(w_reg);
                mem_req.wr_data = val_reg;
                w_next          = w_reg + CNT_W'(1);
                count_next      = count_reg + CNT_W'(1);
                n_next          = n_reg - CNT_W'(1);
                if (n_reg == CNT_W'(1)) begin
                    state_next = S_DONE;
                end
            end

            S_RD: begin
                rv_next    = rd_data;
                state_next = S_DONE;
            end

            S_DONE: begin
                if (out_free) begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign idle             = (state_reg == S_IDLE);
    assign res.status       = status_reg;
    assign res.entry_count  = 6'(count_reg);
    assign res.read_value   = rv_reg;

endmodule

/* rtl/sorted_multiset_table_top.sv */
`timescale 1ns / 1ps
// With N entries held, insert, delete and update walk the table memory, update
// twice; insert when full, delete when empty and a read past the count end
// without a table walk, while a key that is not found still costs the full scan.
// One word is worked at a time, bounded by the simple dual-port table memory walk;
// the next word is taken as soon as the result sits in the output register.
// Reset (aresetn low, synchronous) clears the count and control state; the
// table memory is not cleared and is only read below the count.
module sorted_multiset_table_top (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  smt_pkg::item_t   s_item,
    output logic             m_valid,
    input  logic             m_ready,
    output smt_pkg::result_t m_result
);
    import smt_pkg::*;

    logic                     idle;
    logic                     done;
    logic                     out_free;
    result_t                  res;
    mem_req_t                 mem_req;
    logic signed [DATA_W-1:0] rd_data;
    logic                     m_valid_reg;
    result_t                  m_result_reg;

    assign s_ready  = idle;
    assign out_free = !m_valid_reg || m_ready;

    smt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (s_valid && idle),
        .item     (s_item),
        .idle     (idle),
        .out_free (out_free),
        .done     (done),
        .res      (res),
        .mem_req  (mem_req),
        .rd_data  (rd_data)
    );

    smt_ram u_ram (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (done) begin
            m_result_reg <= res;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = m_result_reg;

endmodule
